### rtl/core/rpt_pkg.sv
`default_nettype none

package rpt_pkg;

  // Field widths of the channels and the configuration port.
  localparam int TEXT_W     = 11;
  localparam int GRID_W     = 9;
  localparam int ROW_W      = 17;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 16;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Row layout.
  localparam int ROW_COLUMNS = 64;
  localparam int FRAME_COLS  = 8;
  localparam int HEIGHT_END  = 36;

  // Limits of a valid configuration.
  localparam int MAX_TEXT_ROWS = 1024;
  localparam int MAX_GRID_SIDE = 256;
  localparam int TEXT_LIM_W    = 13;
  localparam int GRID_LIM_W    = 11;
  localparam logic [TEXT_LIM_W-1:0] TEXT_LIMIT = TEXT_LIM_W'(MAX_TEXT_ROWS);
  localparam logic [GRID_LIM_W-1:0] GRID_LIMIT = GRID_LIM_W'(MAX_GRID_SIDE);

  // Position decode.
  localparam int POS_W     = 12;
  localparam int MAG_W     = 11;
  localparam int SEQ_W     = 19;
  localparam int DIV_STEPS = ROW_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Frequency table: powers of 10000^(-1/56) in Q1.32, entry 0 is 1.0.
  localparam int POW_COUNT = 55;
  localparam int EXP_W     = 6;
  localparam int POW_W     = 33;
  localparam logic [63:0] R_Q32 = 64'd3643605004;

  // Angle datapath.
  localparam int PROD_W       = MAG_W + POW_W;
  localparam int RED_W        = PROD_W;
  localparam int REDUCE_STEPS = 8;
  localparam int ZW           = 37;
  localparam int XW           = 34;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [RED_W-1:0]     TWO_PI_RED     = 44'd26986075410;
  localparam logic signed [ZW-1:0] PI_Z           = 37'sd13493037705;
  localparam logic signed [ZW-1:0] TWO_PI_Z       = 37'sd26986075410;
  localparam logic signed [ZW-1:0] HALF_PI_Z      = 37'sd6746518853;
  localparam logic signed [ZW-1:0] NEG_HALF_PI_Z  = -37'sd6746518853;
  localparam logic signed [XW-1:0] GAIN_X         = 34'sd652032874;

  // Output rounding to Q1.15.
  localparam int Q15_SHIFT = 15;
  localparam logic signed [XW:0] ROUND_BIAS = 35'sd16384;
  localparam logic signed [XW:0] SAT_HI     = 35'sd32767;
  localparam logic signed [XW:0] SAT_LO     = -35'sd32768;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COUNT,
    CFG_VALID_COUNT,
    CFG_GRID_H,
    CFG_GRID_W
  } cfg_idx_t;

  typedef struct packed {
    logic [TEXT_W-1:0] text_count;
    logic [TEXT_W-1:0] valid_count;
    logic [GRID_W-1:0] grid_h;
    logic [GRID_W-1:0] grid_w;
  } cfg_t;

  // Decoded positions of one requested row.
  typedef struct packed {
    logic                    bad;
    logic signed [POS_W-1:0] fpos;
    logic signed [POS_W-1:0] hpos;
    logic signed [POS_W-1:0] wpos;
  } pos_rec_t;

  // Control that travels with every beat through the pipeline.
  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
    logic             bad;
    logic             last;
    logic             neg;
    logic             flip;
  } tag_t;

  typedef logic [POW_W-1:0] pow_tab_t [POW_COUNT];

  // Each power is the previous one times R, rounded to nearest.
  function automatic pow_tab_t build_pow_table();
    pow_tab_t    tab;
    logic [63:0] p;
    p = 64'd1 << 32;
    tab[0] = p[POW_W-1:0];
    for (int e = 1; e < POW_COUNT; e++) begin
      p = (p * R_Q32 + (64'd1 << 31)) >> 32;
      tab[e] = p[POW_W-1:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TABLE = build_pow_table();

  // Arctangent of 2^-i in Q.32; beyond ten it equals 2^-i.
  function automatic logic signed [ZW-1:0] atan_q32(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 37'sd3373259426;
      1:  a = 37'sd1991351318;
      2:  a = 37'sd1052175346;
      3:  a = 37'sd534125996;
      4:  a = 37'sd268086748;
      5:  a = 37'sd134174063;
      6:  a = 37'sd67103403;
      7:  a = 37'sd33553749;
      8:  a = 37'sd16777131;
      9:  a = 37'sd8388597;
      10: a = 37'sd4194303;
      default: a = 37'sd1 <<< (32 - i);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rpt_in_if.sv
`default_nettype none

interface rpt_in_if import rpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] token_row;

  modport source (output valid, output token_row, input ready);
  modport sink   (input valid, input token_row, output ready);
endinterface

`default_nettype wire

### rtl/core/rpt_out_if.sv
`default_nettype none

interface rpt_out_if import rpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column;
  logic signed [VAL_W-1:0] cos_value;
  logic signed [VAL_W-1:0] sin_value;
  logic                    bad_request;
  logic                    last_of_row;

  modport source (output valid, output column, output cos_value, output sin_value,
                  output bad_request, output last_of_row, input ready);
  modport sink   (input valid, input column, input cos_value, input sin_value,
                  input bad_request, input last_of_row, output ready);
endinterface

`default_nettype wire

### rtl/core/rpt_pos_unit.sv
`default_nettype none

module rpt_pos_unit import rpt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rpt_in_if.sink    in_ch,
  input  wire cfg_t cfg,
  output logic      res_vld,
  input  wire logic res_rdy,
  output pos_rec_t  res
);

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      quo_r;
  logic [GRID_W-1:0]     rem_r;
  logic                  res_vld_r, res_vld_nxt;
  pos_rec_t              res_r, rec_nxt;

  logic                  accept, stepping, finish;
  logic [GRID_W:0]       trial, diff;
  logic                  ge;
  logic [GRID_W-1:0]     rem_step;
  logic [2*GRID_W-1:0]   area;
  logic [SEQ_W-1:0]      seq_len;
  logic                  cfg_bad, row_bad, is_text;
  logic [GRID_W:0]       h_half, w_half;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign stepping    = busy_r && (cnt_r != '0);
  assign finish      = busy_r && (cnt_r == '0) && (!res_vld_r || res_rdy);

  // One restoring division step: offset / grid width, one quotient bit a cycle.
  always_comb begin
    trial    = {rem_r, quo_r[ROW_W-1]};
    diff     = trial - {1'b0, cfg.grid_w};
    ge       = trial >= {1'b0, cfg.grid_w};
    rem_step = ge ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
  end

  // Range checks and final positions once the division has finished.
  always_comb begin
    area    = cfg.grid_h * cfg.grid_w;
    seq_len = {{(SEQ_W-TEXT_W){1'b0}}, cfg.text_count} + {1'b0, area};
    cfg_bad = (cfg.text_count == '0) || (cfg.grid_h == '0) || (cfg.grid_w == '0) ||
              ({2'b0, cfg.text_count} > TEXT_LIMIT) ||
              ({2'b0, cfg.valid_count} > TEXT_LIMIT) ||
              ({2'b0, cfg.grid_h} > GRID_LIMIT) ||
              ({2'b0, cfg.grid_w} > GRID_LIMIT);
    row_bad = {{(SEQ_W-ROW_W){1'b0}}, row_r} >= seq_len;
    is_text = row_r < {{(ROW_W-TEXT_W){1'b0}}, cfg.text_count};
    h_half  = ({1'b0, cfg.grid_h} + 1'b1) >> 1;
    w_half  = ({1'b0, cfg.grid_w} + 1'b1) >> 1;

    rec_nxt.bad = cfg_bad || row_bad;
    if (is_text) begin
      rec_nxt.fpos = $signed({{(POS_W-TEXT_W){1'b0}}, row_r[TEXT_W-1:0]});
      rec_nxt.hpos = rec_nxt.fpos;
      rec_nxt.wpos = rec_nxt.fpos;
    end else begin
      rec_nxt.fpos = $signed({{(POS_W-TEXT_W){1'b0}}, cfg.valid_count});
      rec_nxt.hpos = $signed({{(POS_W-GRID_W){1'b0}}, quo_r[GRID_W-1:0]}) -
                     $signed({{(POS_W-GRID_W-1){1'b0}}, h_half});
      rec_nxt.wpos = $signed({{(POS_W-GRID_W){1'b0}}, rem_r}) -
                     $signed({{(POS_W-GRID_W-1){1'b0}}, w_half});
    end
  end

  // Control next state.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = CNT_W'(DIV_STEPS);
    end else if (stepping) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    res_vld_nxt = finish || (res_vld_r && !res_rdy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Division registers and the result buffer.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_ch.token_row;
      quo_r <= in_ch.token_row - {{(ROW_W-TEXT_W){1'b0}}, cfg.text_count};
      rem_r <= '0;
    end else if (stepping) begin
      quo_r <= {quo_r[ROW_W-2:0], ge};
      rem_r <= rem_step;
    end
    if (finish) begin
      res_r <= rec_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire

### rtl/core/rpt_col_seq.sv
`default_nettype none

module rpt_col_seq import rpt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     rec_vld,
  output logic          rec_rdy,
  input  wire pos_rec_t rec,
  output tag_t          iss_tag,
  output logic [MAG_W-1:0] iss_mag,
  output logic [EXP_W-1:0] iss_e
);

  logic             act_r, act_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  pos_rec_t         rec_r;
  tag_t             iss_tag_r, beat_tag;
  logic [MAG_W-1:0] iss_mag_r;
  logic [EXP_W-1:0] iss_e_r;

  logic                    final_beat, load;
  logic signed [POS_W-1:0] pos_cur, pos_abs;
  logic [EXP_W-1:0]        e_cur;

  assign final_beat = rec_r.bad || (col_r == COL_W'(ROW_COLUMNS - 1));
  assign rec_rdy    = !act_r || (en && final_beat);
  assign load       = rec_vld && rec_rdy;

  // Pick the axis and the frequency exponent of the current column.
  always_comb begin
    if (col_r < COL_W'(FRAME_COLS)) begin
      pos_cur = rec_r.fpos;
      e_cur   = EXP_W'(col_r * COL_W'(7));
    end else if (col_r < COL_W'(HEIGHT_END)) begin
      pos_cur = rec_r.hpos;
      e_cur   = EXP_W'((col_r - COL_W'(FRAME_COLS)) << 1);
    end else begin
      pos_cur = rec_r.wpos;
      e_cur   = EXP_W'((col_r - COL_W'(HEIGHT_END)) << 1);
    end
    pos_abs = pos_cur[POS_W-1] ? -pos_cur : pos_cur;

    beat_tag.vld  = act_r;
    beat_tag.col  = col_r;
    beat_tag.bad  = rec_r.bad;
    beat_tag.last = final_beat;
    beat_tag.neg  = pos_cur[POS_W-1];
    beat_tag.flip = 1'b0;
  end

  // Row and column bookkeeping.
  always_comb begin
    act_nxt = act_r;
    col_nxt = col_r;
    if (load) begin
      act_nxt = 1'b1;
      col_nxt = '0;
    end else if (en && act_r) begin
      if (final_beat) begin
        act_nxt = 1'b0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      col_r     <= '0;
      iss_tag_r <= '0;
    end else begin
      act_r <= act_nxt;
      col_r <= col_nxt;
      if (en) begin
        iss_tag_r <= beat_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec;
    end
    if (en) begin
      iss_mag_r <= pos_abs[MAG_W-1:0];
      iss_e_r   <= e_cur;
    end
  end

  assign iss_tag = iss_tag_r;
  assign iss_mag = iss_mag_r;
  assign iss_e   = iss_e_r;

  // A running row steps one column per transfer.
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && en && !final_beat && !load |=> act_r && (col_r == $past(col_r) + 1'b1))
    else $error("column counter did not advance");

  // A newly taken row starts at column zero.
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> act_r && (col_r == '0))
    else $error("new row did not start at column zero");

  // An error row never leaves column zero.
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && rec_r.bad |-> col_r == '0)
    else $error("error row issued more than one beat");

endmodule

`default_nettype wire

### rtl/core/rpt_reduce_cell.sv
`default_nettype none

module rpt_reduce_cell import rpt_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire tag_t             tag_i,
  input  wire logic [RED_W-1:0] v_i,
  output tag_t                  tag_o,
  output logic [RED_W-1:0]      v_o
);

  localparam logic [RED_W-1:0] SUB = TWO_PI_RED << SHIFT;

  tag_t             tag_r;
  logic [RED_W-1:0] v_r, v_nxt;

  // Remove one multiple of 2*pi scaled by this cell's power of two.
  assign v_nxt = (v_i >= SUB) ? v_i - SUB : v_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign tag_o = tag_r;
  assign v_o   = v_r;

endmodule

`default_nettype wire

### rtl/core/rpt_cordic_cell.sv
`default_nettype none

module rpt_cordic_cell import rpt_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire tag_t                 tag_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic signed [ZW-1:0] z_i,
  output tag_t                      tag_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [ZW-1:0]      z_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q32(STAGE);

  tag_t                 tag_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, x_sh, y_sh;
  logic signed [ZW-1:0] z_r, z_nxt;

  // One rotation toward zero residual angle.
  always_comb begin
    x_sh = x_i >>> STAGE;
    y_sh = y_i >>> STAGE;
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - y_sh;
      y_nxt = y_i + x_sh;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + y_sh;
      y_nxt = y_i - x_sh;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

### rtl/core/rotary_position_table_generator.sv
`default_nettype none

// Rotary cos/sin row generator for a sequence of text rows followed by image rows.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. The four registers
// reset to zero, which makes every request an error until written. Each transfer on
// in_ch names one sequence row. The block answers on out_ch with 64 results, columns
// 0 to 63 in order, last_of_row set on column 63. A row beyond the sequence, or any
// row under an invalid configuration, gets one error result instead. The offset
// divider produces one quotient bit per cycle and takes a new row only after the
// decoded positions of the last one are in its result buffer. Results
// leave at one per cycle unless the output register holds a result while out_ch.ready
// is low; that stalls the whole result pipeline, and no result is lost or repeated.
// The divider and one decoded row keep accepting upstream.
// Reset is synchronous, active low, and empties the pipeline.

module rotary_position_table_generator import rpt_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rpt_in_if.sink                     in_ch,
  rpt_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic en;

  logic     rec_vld, rec_rdy;
  pos_rec_t rec;

  tag_t             iss_tag;
  logic [MAG_W-1:0] iss_mag;
  logic [EXP_W-1:0] iss_e;

  tag_t              mul_tag_r;
  logic [PROD_W-1:0] mul_v_r, mul_v_nxt;

  tag_t             red_tag [REDUCE_STEPS+1];
  logic [RED_W-1:0] red_v   [REDUCE_STEPS+1];

  tag_t                 f1_tag_r, f2_tag_r, f2_tag_nxt;
  logic signed [ZW-1:0] rz, f1_z_r, f1_z_nxt, f2_z_r, f2_z_nxt;
  logic                 rz_gt;

  tag_t                 c_tag [CORDIC_STAGES+1];
  logic signed [XW-1:0] c_x   [CORDIC_STAGES+1];
  logic signed [XW-1:0] c_y   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] c_z   [CORDIC_STAGES+1];

  tag_t                    ng_tag_r, out_tag_r;
  logic signed [XW-1:0]    ng_x_r, ng_y_r;
  logic signed [VAL_W-1:0] out_cos_r, out_sin_r, out_cos_nxt, out_sin_nxt;

  // Round Q4.30 to Q1.15 and saturate.
  function automatic logic signed [VAL_W-1:0] round_q15(input logic signed [XW-1:0] v);
    logic signed [XW:0] sum;
    logic signed [XW:0] q;
    sum = {v[XW-1], v} + ROUND_BIAS;
    q   = sum >>> Q15_SHIFT;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[VAL_W-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEXT_COUNT:  cfg_r.text_count  <= cfg_wdata;
        CFG_VALID_COUNT: cfg_r.valid_count <= cfg_wdata;
        CFG_GRID_H:      cfg_r.grid_h      <= cfg_wdata[GRID_W-1:0];
        CFG_GRID_W:      cfg_r.grid_w      <= cfg_wdata[GRID_W-1:0];
      endcase
    end
  end

  // The whole result pipeline moves whenever the output register can take a beat.
  assign en = !out_tag_r.vld || out_ch.ready;

  rpt_pos_unit u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .res_vld (rec_vld),
    .res_rdy (rec_rdy),
    .res     (rec)
  );

  rpt_col_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rec_vld (rec_vld),
    .rec_rdy (rec_rdy),
    .rec     (rec),
    .iss_tag (iss_tag),
    .iss_mag (iss_mag),
    .iss_e   (iss_e)
  );

  // Angle magnitude: |position| times the column's inverse frequency, Q.32.
  assign mul_v_nxt = {{(PROD_W-MAG_W){1'b0}}, iss_mag} *
                     {{(PROD_W-POW_W){1'b0}}, POW_TABLE[iss_e]};

  assign red_tag[0] = mul_tag_r;
  assign red_v[0]   = mul_v_r;

  // Reduction modulo 2*pi, one quotient bit per cell.
  for (genvar k = 0; k < REDUCE_STEPS; k++) begin : g_reduce
    rpt_reduce_cell #(
      .SHIFT (REDUCE_STEPS - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tag_i (red_tag[k]),
      .v_i   (red_v[k]),
      .tag_o (red_tag[k+1]),
      .v_o   (red_v[k+1])
    );
  end

  // Map the reduced angle into [-pi, pi] and apply the sign of the position.
  always_comb begin
    rz    = $signed({1'b0, red_v[REDUCE_STEPS][ZW-2:0]});
    rz_gt = rz > PI_Z;
    unique case ({red_tag[REDUCE_STEPS].neg, rz_gt})
      2'b00:   f1_z_nxt = rz;
      2'b01:   f1_z_nxt = rz - TWO_PI_Z;
      2'b10:   f1_z_nxt = -rz;
      default: f1_z_nxt = TWO_PI_Z - rz;
    endcase
  end

  // Fold into [-pi/2, pi/2]; the result is negated at the end when folded.
  always_comb begin
    f2_tag_nxt = f1_tag_r;
    priority if (f1_z_r > HALF_PI_Z) begin
      f2_z_nxt        = f1_z_r - PI_Z;
      f2_tag_nxt.flip = 1'b1;
    end else if (f1_z_r < NEG_HALF_PI_Z) begin
      f2_z_nxt        = f1_z_r + PI_Z;
      f2_tag_nxt.flip = 1'b1;
    end else begin
      f2_z_nxt        = f1_z_r;
      f2_tag_nxt.flip = 1'b0;
    end
  end

  assign c_tag[0] = f2_tag_r;
  assign c_x[0]   = GAIN_X;
  assign c_y[0]   = '0;
  assign c_z[0]   = f2_z_r;

  // Rotation chain.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    rpt_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tag_i (c_tag[i]),
      .x_i   (c_x[i]),
      .y_i   (c_y[i]),
      .z_i   (c_z[i]),
      .tag_o (c_tag[i+1]),
      .x_o   (c_x[i+1]),
      .y_o   (c_y[i+1]),
      .z_o   (c_z[i+1])
    );
  end

  // Output values; an error result carries zeros.
  always_comb begin
    out_cos_nxt = ng_tag_r.bad ? '0 : round_q15(ng_x_r);
    out_sin_nxt = ng_tag_r.bad ? '0 : round_q15(ng_y_r);
  end

  // Beat control through the local stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_tag_r <= '0;
      f1_tag_r  <= '0;
      f2_tag_r  <= '0;
      ng_tag_r  <= '0;
      out_tag_r <= '0;
    end else if (en) begin
      mul_tag_r <= iss_tag;
      f1_tag_r  <= red_tag[REDUCE_STEPS];
      f2_tag_r  <= f2_tag_nxt;
      ng_tag_r  <= c_tag[CORDIC_STAGES];
      out_tag_r <= ng_tag_r;
    end
  end

  // Data of the local stages.
  always_ff @(posedge clk) begin
    if (en) begin
      mul_v_r   <= mul_v_nxt;
      f1_z_r    <= f1_z_nxt;
      f2_z_r    <= f2_z_nxt;
      ng_x_r    <= c_tag[CORDIC_STAGES].flip ? -c_x[CORDIC_STAGES] : c_x[CORDIC_STAGES];
      ng_y_r    <= c_tag[CORDIC_STAGES].flip ? -c_y[CORDIC_STAGES] : c_y[CORDIC_STAGES];
      out_cos_r <= out_cos_nxt;
      out_sin_r <= out_sin_nxt;
    end
  end

  assign out_ch.valid       = out_tag_r.vld;
  assign out_ch.column      = out_tag_r.col;
  assign out_ch.bad_request = out_tag_r.bad;
  assign out_ch.last_of_row = out_tag_r.last;
  assign out_ch.cos_value   = out_cos_r;
  assign out_ch.sin_value   = out_sin_r;

  // An error result is a single zero beat at column zero.
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_request |->
      out_ch.last_of_row && (out_ch.column == '0) &&
      (out_ch.cos_value == '0) && (out_ch.sin_value == '0))
    else $error("malformed error result");

  // Only column 63 of a normal row closes it.
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.bad_request |->
      (out_ch.last_of_row == (out_ch.column == COL_W'(ROW_COLUMNS - 1))))
    else $error("last_of_row does not match the final column");

  // The divider is busy right after it takes a row.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while divider busy");

endmodule

`default_nettype wire
